// ===== sv/vpfa_pkg.sv =====
// Shared types and constants for the video payload frame assembly unit.
package vpfa_pkg;

    localparam int LEN_W   = 24;
    localparam int PLEN_W  = 16;
    localparam int HDR_W   = 8;
    localparam int CODE_W  = 3;
    localparam int COUNT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [CODE_W-1:0] ST_SKIPPED  = 3'd0;
    localparam logic [CODE_W-1:0] ST_TAKEN    = 3'd1;
    localparam logic [CODE_W-1:0] ST_WHOLE    = 3'd2;
    localparam logic [CODE_W-1:0] ST_BEFORE   = 3'd3;
    localparam logic [CODE_W-1:0] ST_RELEASED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 2'd1;

    localparam logic [HDR_W-1:0] HEADER_MIN = 8'd2;
    localparam int FLAG_TOGGLE_BIT = 0;
    localparam int FLAG_EOF_BIT    = 1;
    localparam int FLAG_ERROR_BIT  = 6;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_SHORT   = 2'd1,
        KIND_BAD_HDR = 2'd2,
        KIND_RELEASE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               toggle;
        logic               eof;
        logic               error;
        logic [PLEN_W-1:0]  data_len;
    } item_t;

endpackage

// ===== sv/video_payload_frame_assembly_unit.sv =====
// Top level of the video payload frame assembly unit.
// The unit takes one transaction per clock cycle while its queue is not full, either a payload
// header or a release command, and returns one result transaction for each, in order. A
// transaction passes through the classifying front end into a two-entry queue, and the back end
// updates the frame state and loads the result register in the cycle it leaves the queue. The
// frame state update in the back end sets the sustained rate of one transaction per cycle
// whilst the result side keeps taking results.
// Configuration writes are always accepted and take effect on the next cycle.
module video_payload_frame_assembly_unit #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vpfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vpfa_pkg::LEN_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [vpfa_pkg::HDR_W-1:0]     s_header_len,
    input  logic [vpfa_pkg::HDR_W-1:0]     s_header_flags,
    input  logic [vpfa_pkg::PLEN_W-1:0]    s_payload_len,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vpfa_pkg::CODE_W-1:0]    m_step_code,
    output logic                           m_copy_enable,
    output logic [vpfa_pkg::LEN_W-1:0]     m_copy_offset,
    output logic [vpfa_pkg::PLEN_W-1:0]    m_copy_count,
    output logic [vpfa_pkg::LEN_W-1:0]     m_frame_bytes,
    output logic [vpfa_pkg::COUNT_W-1:0]   m_whole_total,
    output logic [vpfa_pkg::COUNT_W-1:0]   m_dropped_total
);
    import vpfa_pkg::*;

    item_t front_item;
    item_t q_item;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;

    assign s_ready = !q_full;

    vpfa_front u_front (
        .s_command      (s_command),
        .s_header_len   (s_header_len),
        .s_header_flags (s_header_flags),
        .s_payload_len  (s_payload_len),
        .item           (front_item)
    );

    vpfa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    vpfa_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_not_empty     (q_not_empty),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_step_code     (m_step_code),
        .m_copy_enable   (m_copy_enable),
        .m_copy_offset   (m_copy_offset),
        .m_copy_count    (m_copy_count),
        .m_frame_bytes   (m_frame_bytes),
        .m_whole_total   (m_whole_total),
        .m_dropped_total (m_dropped_total)
    );

endmodule

// ===== sv/vpfa_front.sv =====
// Front end: classifies each incoming transaction before it is queued.
module vpfa_front (
    input  logic                        s_command,
    input  logic [vpfa_pkg::HDR_W-1:0]  s_header_len,
    input  logic [vpfa_pkg::HDR_W-1:0]  s_header_flags,
    input  logic [vpfa_pkg::PLEN_W-1:0] s_payload_len,
    output vpfa_pkg::item_t             item
);
    import vpfa_pkg::*;

    logic short_len;
    logic bad_hdr;

    assign short_len = s_payload_len < PLEN_W'(HEADER_MIN);
    assign bad_hdr   = (s_header_len < HEADER_MIN) ||
                       (PLEN_W'(s_header_len) > s_payload_len);

    always_comb begin
        item.toggle   = s_header_flags[FLAG_TOGGLE_BIT];
        item.eof      = s_header_flags[FLAG_EOF_BIT];
        item.error    = s_header_flags[FLAG_ERROR_BIT];
        item.data_len = s_payload_len - PLEN_W'(s_header_len);
        if (s_command) begin
            item.kind = KIND_RELEASE;
        end else if (short_len) begin
            item.kind = KIND_SHORT;
        end else if (bad_hdr) begin
            item.kind = KIND_BAD_HDR;
        end else begin
            item.kind = KIND_PAYLOAD;
        end
    end

endmodule

// ===== sv/vpfa_queue.sv =====
// Two-entry queue of classified transactions between the front and back ends.
module vpfa_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  vpfa_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output vpfa_pkg::item_t pop_item
);
    import vpfa_pkg::*;

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/vpfa_back.sv =====
// Back end: frame state, configuration registers and the registered result.
module vpfa_back #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vpfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vpfa_pkg::LEN_W-1:0]     cfg_data,
    input  logic                           q_not_empty,
    input  vpfa_pkg::item_t                q_item,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vpfa_pkg::CODE_W-1:0]    m_step_code,
    output logic                           m_copy_enable,
    output logic [vpfa_pkg::LEN_W-1:0]     m_copy_offset,
    output logic [vpfa_pkg::PLEN_W-1:0]    m_copy_count,
    output logic [vpfa_pkg::LEN_W-1:0]     m_frame_bytes,
    output logic [vpfa_pkg::COUNT_W-1:0]   m_whole_total,
    output logic [vpfa_pkg::COUNT_W-1:0]   m_dropped_total
);
    import vpfa_pkg::*;

    localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    logic [LEN_W-1:0]   capacity_reg;
    logic [LEN_W-1:0]   expected_reg;
    logic [LEN_W-1:0]   held_reg;
    logic [LEN_W-1:0]   held_next;
    logic               broken_reg;
    logic               broken_next;
    logic               last_toggle_reg;
    logic               last_toggle_next;
    logic               toggle_valid_reg;
    logic               toggle_valid_next;
    logic               synced_reg;
    logic               synced_next;
    logic [COUNT_W-1:0] whole_reg;
    logic [COUNT_W-1:0] whole_next;
    logic [COUNT_W-1:0] dropped_reg;
    logic [COUNT_W-1:0] dropped_next;
    logic               out_valid_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [CODE_W-1:0]  code_next;
    logic               cen_reg;
    logic               cen_next;
    logic [LEN_W-1:0]   coff_reg;
    logic [LEN_W-1:0]   coff_next;
    logic [PLEN_W-1:0]  ccnt_reg;
    logic [PLEN_W-1:0]  ccnt_next;
    logic [32:0]        limit;
    logic [LEN_W:0]     end_len;
    logic               toggle_change;
    logic               done;

    function automatic logic keepable(input logic [LEN_W-1:0] len, input logic brk,
                                      input logic [LEN_W-1:0] expected);
        return (len != '0) && !brk && ((expected == '0) || (len == expected));
    endfunction

    assign cfg_ready = 1'b1;
    assign q_pop     = q_not_empty && (!out_valid_reg || m_ready);

    assign m_valid         = out_valid_reg;
    assign m_step_code     = code_reg;
    assign m_copy_enable   = cen_reg;
    assign m_copy_offset   = coff_reg;
    assign m_copy_count    = ccnt_reg;
    assign m_frame_bytes   = held_reg;
    assign m_whole_total   = whole_reg;
    assign m_dropped_total = dropped_reg;

    assign limit = ({9'd0, capacity_reg} < LEN_MAX) ? {9'd0, capacity_reg} : LEN_MAX;
    assign toggle_change = toggle_valid_reg && (q_item.toggle != last_toggle_reg);

    always_comb begin
        held_next         = held_reg;
        broken_next       = broken_reg;
        last_toggle_next  = last_toggle_reg;
        toggle_valid_next = toggle_valid_reg;
        synced_next       = synced_reg;
        whole_next        = whole_reg;
        dropped_next      = dropped_reg;
        code_next         = ST_TAKEN;
        cen_next          = 1'b0;
        coff_next         = '0;
        ccnt_next         = '0;
        end_len           = '0;
        done              = 1'b0;
        case (q_item.kind)
            KIND_RELEASE: begin
                held_next         = '0;
                broken_next       = 1'b0;
                toggle_valid_next = 1'b0;
                code_next         = ST_RELEASED;
            end
            KIND_SHORT: begin
                code_next = ST_SKIPPED;
            end
            KIND_BAD_HDR: begin
                if (held_reg != '0) begin
                    broken_next = 1'b1;
                end
                code_next = ST_SKIPPED;
            end
            KIND_PAYLOAD: begin
                if (!synced_reg) begin
                    if (toggle_change) begin
                        synced_next = 1'b1;
                    end else begin
                        if (q_item.eof) begin
                            toggle_valid_next = 1'b0;
                            synced_next       = 1'b1;
                        end else begin
                            toggle_valid_next = 1'b1;
                            last_toggle_next  = q_item.toggle;
                        end
                        code_next = ST_SKIPPED;
                        done      = 1'b1;
                    end
                end
                if (!done && toggle_change) begin
                    if (keepable(held_reg, broken_reg, expected_reg)) begin
                        whole_next = whole_reg + 1'b1;
                        code_next  = ST_BEFORE;
                        done       = 1'b1;
                    end else begin
                        if ((held_reg != '0) || broken_reg) begin
                            dropped_next = dropped_reg + 1'b1;
                        end
                        held_next   = '0;
                        broken_next = 1'b0;
                    end
                end
                if (!done) begin
                    last_toggle_next  = q_item.toggle;
                    toggle_valid_next = 1'b1;
                    if (q_item.error) begin
                        broken_next = 1'b1;
                    end
                    if (q_item.data_len != '0) begin
                        end_len = {1'b0, held_next} + (LEN_W + 1)'(q_item.data_len);
                        if ({8'd0, end_len} > limit) begin
                            broken_next = 1'b1;
                        end else if (!broken_next) begin
                            cen_next  = 1'b1;
                            coff_next = held_next;
                            ccnt_next = q_item.data_len;
                            held_next = end_len[LEN_W-1:0];
                        end
                    end
                    if (q_item.eof) begin
                        if (keepable(held_next, broken_next, expected_reg)) begin
                            whole_next = whole_next + 1'b1;
                            code_next  = ST_WHOLE;
                        end else begin
                            if ((held_next != '0) || broken_next) begin
                                dropped_next = dropped_next + 1'b1;
                            end
                            held_next         = '0;
                            broken_next       = 1'b0;
                            toggle_valid_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
                code_next = ST_SKIPPED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg     <= '0;
            expected_reg     <= '0;
            held_reg         <= '0;
            broken_reg       <= 1'b0;
            last_toggle_reg  <= 1'b0;
            toggle_valid_reg <= 1'b0;
            synced_reg       <= 1'b0;
            whole_reg        <= '0;
            dropped_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == CFG_BUFFER_CAPACITY) begin
                capacity_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_EXPECTED_LENGTH) begin
                expected_reg <= cfg_data;
            end
            if (q_pop) begin
                held_reg         <= held_next;
                broken_reg       <= broken_next;
                last_toggle_reg  <= last_toggle_next;
                toggle_valid_reg <= toggle_valid_next;
                synced_reg       <= synced_next;
                whole_reg        <= whole_next;
                dropped_reg      <= dropped_next;
                out_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            code_reg <= code_next;
            cen_reg  <= cen_next;
            coff_reg <= coff_next;
            ccnt_reg <= ccnt_next;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the video payload frame assembly unit.
module testbench;
    import vpfa_pkg::*;

    localparam bit CMD_PAYLOAD = 1'b0;
    localparam bit CMD_RELEASE = 1'b1;
    localparam logic [HDR_W-1:0] F_TOG = 8'(1 << FLAG_TOGGLE_BIT);
    localparam logic [HDR_W-1:0] F_EOF = 8'(1 << FLAG_EOF_BIT);
    localparam logic [HDR_W-1:0] F_ERR = 8'(1 << FLAG_ERROR_BIT);
    localparam logic [HDR_W-1:0] F_SPARE = ~(F_TOG | F_EOF | F_ERR);
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic               cen;
        logic [LEN_W-1:0]   off;
        logic [PLEN_W-1:0]  cnt;
        logic [LEN_W-1:0]   held;
        logic [COUNT_W-1:0] whole;
        logic [COUNT_W-1:0] dropped;
    } outcome_t;

    class frame_assembly_tracker;
        logic [LEN_W-1:0]   capacity;
        logic [LEN_W-1:0]   expected_len;
        logic [LEN_W-1:0]   held;
        logic               broken;
        logic               last_toggle;
        logic               toggle_seen;
        logic               synced;
        logic [COUNT_W-1:0] whole;
        logic [COUNT_W-1:0] dropped;
        logic               copy_en;
        logic [LEN_W-1:0]   copy_off;
        logic [PLEN_W-1:0]  copy_cnt;
        outcome_t           outcome_q[$];
        int                 errors;

        function new();
            capacity = '0;
            expected_len = '0;
            held = '0;
            broken = 1'b0;
            last_toggle = 1'b0;
            toggle_seen = 1'b0;
            synced = 1'b0;
            whole = '0;
            dropped = '0;
            errors = 0;
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
            case (idx)
                CFG_BUFFER_CAPACITY: capacity = value;
                CFG_EXPECTED_LENGTH: expected_len = value;
                default: ;
            endcase
        endfunction

        function bit keepable();
            return held != 0 && !broken && (expected_len == 0 || held == expected_len);
        endfunction

        function void abandon();
            if (held != 0 || broken) dropped++;
            held = '0;
            broken = 1'b0;
        endfunction

        function logic [CODE_W-1:0] advance(bit cmd, logic [HDR_W-1:0] hdr,
                                            logic [HDR_W-1:0] flags, logic [PLEN_W-1:0] plen);
            logic             tog;
            logic [PLEN_W-1:0] data;
            logic [LEN_W:0]   end_sum;
            if (cmd == CMD_RELEASE) begin
                held = '0;
                broken = 1'b0;
                toggle_seen = 1'b0;
                return ST_RELEASED;
            end
            if (plen < HEADER_MIN) return ST_SKIPPED;
            if (hdr < HEADER_MIN || hdr > plen) begin
                if (held != 0) broken = 1'b1;
                return ST_SKIPPED;
            end
            tog = flags[FLAG_TOGGLE_BIT];
            if (!synced) begin
                if (toggle_seen && tog != last_toggle) begin
                    synced = 1'b1;
                end else begin
                    if (flags[FLAG_EOF_BIT]) begin
                        toggle_seen = 1'b0;
                        synced = 1'b1;
                    end else begin
                        toggle_seen = 1'b1;
                        last_toggle = tog;
                    end
                    return ST_SKIPPED;
                end
            end
            if (toggle_seen && tog != last_toggle) begin
                if (keepable()) begin
                    whole++;
                    return ST_BEFORE;
                end
                abandon();
            end
            last_toggle = tog;
            toggle_seen = 1'b1;
            if (flags[FLAG_ERROR_BIT]) broken = 1'b1;
            data = plen - hdr;
            if (data != 0) begin
                end_sum = {1'b0, held} + data;
                if (end_sum > {1'b0, capacity}) begin
                    broken = 1'b1;
                end else if (!broken) begin
                    copy_en = 1'b1;
                    copy_off = held;
                    copy_cnt = data;
                    held = end_sum[LEN_W-1:0];
                end
            end
            if (flags[FLAG_EOF_BIT]) begin
                if (keepable()) begin
                    whole++;
                    return ST_WHOLE;
                end
                abandon();
                toggle_seen = 1'b0;
            end
            return ST_TAKEN;
        endfunction

        function void note_payload(bit cmd, logic [HDR_W-1:0] hdr,
                                   logic [HDR_W-1:0] flags, logic [PLEN_W-1:0] plen);
            outcome_t o;
            copy_en = 1'b0;
            copy_off = '0;
            copy_cnt = '0;
            o.code = advance(cmd, hdr, flags, plen);
            o.cen = copy_en;
            o.off = copy_off;
            o.cnt = copy_cnt;
            o.held = held;
            o.whole = whole;
            o.dropped = dropped;
            outcome_q.push_back(o);
        endfunction

        task report(string what);
            $display("%0t ns mismatch: %s", $time, what);
            errors++;
        endtask

        task check_outcome(outcome_t got);
            outcome_t want;
            if (outcome_q.size() == 0) begin
                report("result transaction with no payload waiting");
                return;
            end
            want = outcome_q.pop_front();
            if (got.code !== want.code)
                report($sformatf("step_code %0d, expected %0d", got.code, want.code));
            if (got.cen !== want.cen)
                report($sformatf("copy_enable %0d, expected %0d", got.cen, want.cen));
            if (got.off !== want.off)
                report($sformatf("copy_offset %0d, expected %0d", got.off, want.off));
            if (got.cnt !== want.cnt)
                report($sformatf("copy_count %0d, expected %0d", got.cnt, want.cnt));
            if (got.held !== want.held)
                report($sformatf("frame_bytes %0d, expected %0d", got.held, want.held));
            if (got.whole !== want.whole)
                report($sformatf("whole_total %0d, expected %0d", got.whole, want.whole));
            if (got.dropped !== want.dropped)
                report($sformatf("dropped_total %0d, expected %0d", got.dropped, want.dropped));
        endtask

        function int waiting();
            return outcome_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_command;
    logic [HDR_W-1:0]     s_header_len;
    logic [HDR_W-1:0]     s_header_flags;
    logic [PLEN_W-1:0]    s_payload_len;
    logic                 m_valid;
    logic                 m_ready;
    logic [CODE_W-1:0]    m_step_code;
    logic                 m_copy_enable;
    logic [LEN_W-1:0]     m_copy_offset;
    logic [PLEN_W-1:0]    m_copy_count;
    logic [LEN_W-1:0]     m_frame_bytes;
    logic [COUNT_W-1:0]   m_whole_total;
    logic [COUNT_W-1:0]   m_dropped_total;

    frame_assembly_tracker tracker = new();
    int          items_sent = 0;
    bit          no_idle = 1'b0;
    bit          frame_tog = 1'b0;
    bit          reoffer = 1'b0;
    int unsigned frame_target = 0;

    video_payload_frame_assembly_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_header_len    (s_header_len),
        .s_header_flags  (s_header_flags),
        .s_payload_len   (s_payload_len),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_step_code     (m_step_code),
        .m_copy_enable   (m_copy_enable),
        .m_copy_offset   (m_copy_offset),
        .m_copy_count    (m_copy_count),
        .m_frame_bytes   (m_frame_bytes),
        .m_whole_total   (m_whole_total),
        .m_dropped_total (m_dropped_total)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_outcome({m_step_code, m_copy_enable, m_copy_offset, m_copy_count,
                                       m_frame_bytes, m_whole_total, m_dropped_total});
            if (s_valid && s_ready)
                tracker.note_payload(s_command, s_header_len, s_header_flags, s_payload_len);
            if (cfg_valid && cfg_ready)
                tracker.write_config(cfg_index, cfg_data);
        end
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_item(input bit cmd, input logic [HDR_W-1:0] hdr,
                             input logic [HDR_W-1:0] flags, input logic [PLEN_W-1:0] plen);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_header_len <= hdr;
        s_header_flags <= flags;
        s_payload_len <= plen;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_release();
        send_item(CMD_RELEASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)));
    endtask

    task automatic send_noise();
        bit cmd;
        logic [PLEN_W-1:0] plen;
        cmd = ($urandom_range(0, 7) == 0);
        plen = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom_range(0, 65535));
        send_item(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), plen);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        int guard;
        s_valid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (tracker.waiting() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_frame(input int n);
        int          i;
        int unsigned left;
        int unsigned part;
        bit          eof_close;
        logic [HDR_W-1:0]  hdr;
        logic [HDR_W-1:0]  flags;
        logic [PLEN_W-1:0] plen;
        frame_tog = !frame_tog;
        eof_close = $urandom_range(0, 1);
        left = frame_target;
        for (i = 0; i < n; i++) begin
            hdr = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(2, 255))
                                                : 8'($urandom_range(2, 16));
            if (frame_target != 0) begin
                part = (i == n - 1) ? left : $urandom_range(0, left);
                if (part > 65535 - hdr) part = 65535 - hdr;
                left -= part;
            end else begin
                part = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535 - hdr)
                                                     : $urandom_range(0, 700);
            end
            flags = 8'($urandom_range(0, 255)) & F_SPARE;
            if (frame_tog) flags |= F_TOG;
            if ($urandom_range(0, 24) == 0) flags |= F_ERR;
            if (i == n - 1 && eof_close) flags |= F_EOF;
            plen = 16'(hdr + part);
            if (i == 0 && reoffer) begin
                send_item(CMD_PAYLOAD, hdr, flags, plen);
                if ($urandom_range(0, 7) != 0) send_release();
                reoffer = 1'b0;
            end
            if ($urandom_range(0, 29) == 0) send_noise();
            send_item(CMD_PAYLOAD, hdr, flags, plen);
        end
        if (eof_close) begin
            if ($urandom_range(0, 7) != 0) send_release();
            reoffer = 1'b0;
        end else begin
            reoffer = 1'b1;
        end
    endtask

    initial begin
        int phase;
        int phase_end;
        logic [LEN_W-1:0] cap;
        logic [LEN_W-1:0] expl;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_command = 1'b0;
        s_header_len = '0;
        s_header_flags = '0;
        s_payload_len = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_register(CFG_INDEX_UNUSED_A, 24'($urandom_range(0, LEN_MAX)));
        write_register(CFG_INDEX_UNUSED_B, 24'($urandom_range(0, LEN_MAX)));
        write_register(CFG_BUFFER_CAPACITY, LEN_MAX);
        write_register(CFG_EXPECTED_LENGTH, '0);

        send_item(CMD_PAYLOAD, 8'd0, 8'h00, 16'd0);
        send_item(CMD_PAYLOAD, 8'd2, 8'h00, 16'd1);
        send_item(CMD_PAYLOAD, 8'd2, 8'h00, 16'd10);
        send_item(CMD_PAYLOAD, 8'd0, 8'h00, 16'd10);
        send_item(CMD_PAYLOAD, 8'd1, 8'h00, 16'd10);
        send_item(CMD_PAYLOAD, 8'd20, 8'h00, 16'd10);
        send_item(CMD_PAYLOAD, 8'd2, F_TOG, 16'd100);
        send_item(CMD_PAYLOAD, 8'd12, F_TOG, 16'd12);
        send_item(CMD_PAYLOAD, 8'd0, F_TOG, 16'd40);
        send_item(CMD_PAYLOAD, 8'd2, F_TOG | F_EOF, 16'd30);
        send_item(CMD_PAYLOAD, 8'd255, 8'h00, 16'd65535);
        send_item(CMD_PAYLOAD, 8'd2, 8'h00, 16'd600);
        send_item(CMD_PAYLOAD, 8'd2, F_TOG, 16'd300);
        send_item(CMD_RELEASE, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(CMD_PAYLOAD, 8'd2, F_TOG, 16'd300);
        send_item(CMD_PAYLOAD, 8'd2, F_TOG | F_EOF, 16'd50);
        send_item(CMD_RELEASE, 8'h00, 8'h00, 16'h0000);
        send_item(CMD_PAYLOAD, 8'd2, F_ERR, 16'd40);
        send_item(CMD_PAYLOAD, 8'd2, F_EOF, 16'd40);
        send_item(CMD_PAYLOAD, 8'd2, F_TOG, 16'd1002);
        settle();
        write_register(CFG_BUFFER_CAPACITY, 24'd500);
        send_item(CMD_PAYLOAD, 8'd2, F_TOG, 16'd12);
        send_item(CMD_PAYLOAD, 8'd2, F_TOG | F_EOF, 16'd2);
        settle();
        write_register(CFG_BUFFER_CAPACITY, '0);
        send_item(CMD_PAYLOAD, 8'd2, 8'h00, 16'd2);
        send_item(CMD_PAYLOAD, 8'd2, F_SPARE | F_EOF, 16'd3);
        send_item(CMD_RELEASE, 8'h00, 8'h00, 16'h0000);
        settle();

        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    cap = LEN_MAX;
                    expl = '0;
                end
                1: begin
                    cap = '0;
                    expl = '0;
                end
                2: begin
                    cap = 24'($urandom_range(1000, 6000));
                    expl = '0;
                end
                3: begin
                    cap = LEN_MAX;
                    expl = 24'd1200;
                end
                4: begin
                    cap = 24'($urandom_range(0, LEN_MAX));
                    expl = LEN_MAX;
                end
                5: begin
                    cap = LEN_MAX;
                    expl = 24'($urandom_range(1, 4000));
                end
                default: begin
                    cap = 24'($urandom_range(2000, 60000));
                    expl = 24'($urandom_range(1, 3000));
                end
            endcase
            frame_target = (expl == LEN_MAX) ? 0 : expl;
            write_register(CFG_BUFFER_CAPACITY, cap);
            write_register(CFG_EXPECTED_LENGTH, expl);
            phase_end = items_sent + 130;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 11) == 0) no_idle = !no_idle;
                case ($urandom_range(0, 9))
                    8: send_noise();
                    9: send_release();
                    default: send_frame($urandom_range(1, 6));
                endcase
                if ($urandom_range(0, 99) == 0) settle();
            end
            settle();
        end

        settle();
        repeat (20) @(posedge aclk);
        if (tracker.waiting() != 0) tracker.report("expected results left over at the end");
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/vpfa_pkg.sv
sv/vpfa_front.sv
sv/vpfa_queue.sv
sv/vpfa_back.sv
sv/video_payload_frame_assembly_unit.sv
tb/testbench.sv
